FILE: src/assert_macros.svh
// assertion helpers used by the lane module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   `ASSERT_PROP(label, (ante) |=> (cons), msg)

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
   `ASSERT_PROP(label, (ante) |-> (cons), msg)

`endif

FILE: src/bpc_pkg.sv
package bpc_pkg;

   // field widths
   localparam int TIME_W  = 32;
   localparam int THR_W   = 16;
   localparam int PIN_W   = 4;
   localparam int IDX_W   = 3;
   localparam int MASK_W  = 4;
   localparam int CSR_DW  = 32;
   localparam int CSR_AW  = 4;

   // register reset values
   localparam logic [THR_W-1:0] DEBOUNCE_RST       = 16'd50;
   localparam logic [THR_W-1:0] LONG_HOLD_RST      = 16'd600;
   localparam logic [THR_W-1:0] VERY_LONG_HOLD_RST = 16'd3000;

   typedef enum logic [0:0] {
      CMD_SAMPLE = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REG_DEBOUNCE       = 2'd0,
      REG_LONG_HOLD      = 2'd1,
      REG_VERY_LONG_HOLD = 2'd2
   } reg_idx_type;

   // per-button control from the top level
   typedef struct packed {
      logic              sample;
      logic              clear;
      logic              down;
      logic [TIME_W-1:0] now_ms;
      logic [THR_W-1:0]  debounce_ms;
      logic [THR_W-1:0]  long_hold_ms;
      logic [THR_W-1:0]  very_long_hold_ms;
   } lane_ctl_type;

   // per-button status back to the top level
   typedef struct packed {
      logic held;
      logic held_next;
      logic short_pending;
      logic long_pending;
      logic very_long_pending;
   } lane_stat_type;

endpackage

FILE: src/bpc_if.sv
// request word channel
interface bpc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [bpc_pkg::TIME_W-1:0]   now_ms;
   logic [bpc_pkg::PIN_W-1:0]    pin_low_mask;
   logic [bpc_pkg::IDX_W-1:0]    button_index;

   modport source (output valid, cmd, now_ms, pin_low_mask, button_index, input ready);
   modport sink (input valid, cmd, now_ms, pin_low_mask, button_index, output ready);
endinterface

// response word channel
interface bpc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         short_press;
   logic                         long_press;
   logic                         very_long_press;
   logic                         is_held;
   logic [bpc_pkg::MASK_W-1:0]   held_mask;

   modport source (output valid, short_press, long_press, very_long_press, is_held,
                   held_mask, input ready);
   modport sink (input valid, short_press, long_press, very_long_press, is_held,
                 held_mask, output ready);
endinterface

FILE: src/bpc_lane.sv
`include "assert_macros.svh"

module bpc_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  bpc_pkg::lane_ctl_type ctl,
   output bpc_pkg::lane_stat_type stat
);

   logic                        held_ff, held_in;
   logic                        long_fired_ff, long_fired_in;
   logic                        vlong_fired_ff, vlong_fired_in;
   logic                        short_ff, short_in;
   logic                        long_ff, long_in;
   logic                        vlong_ff, vlong_in;
   logic [bpc_pkg::TIME_W-1:0]  press_time_ff, press_time_in;
   logic [bpc_pkg::TIME_W-1:0]  release_time_ff, release_time_in;

   logic [bpc_pkg::TIME_W-1:0]  since_rel;
   logic [bpc_pkg::TIME_W-1:0]  since_press;
   logic [bpc_pkg::TIME_W-1:0]  dur;
   logic                        press_ok;
   logic                        rel_ok;
   logic                        lf_mid;
   logic                        vf_mid;

   // elapsed times, wrapping
   assign since_rel   = ctl.now_ms - release_time_ff;
   assign since_press = ctl.now_ms - press_time_ff;

   // debounced edges
   assign press_ok = ctl.down && !held_ff &&
                     (since_rel >= bpc_pkg::TIME_W'(ctl.debounce_ms));
   assign rel_ok   = !ctl.down && held_ff &&
                     (since_press >= bpc_pkg::TIME_W'(ctl.debounce_ms));

   // fired flags after edge handling, hold time from the new press time
   assign lf_mid = press_ok ? 1'b0 : long_fired_ff;
   assign vf_mid = press_ok ? 1'b0 : vlong_fired_ff;
   assign dur    = press_ok ? '0 : since_press;

   // next state
   always_comb begin
      held_in         = held_ff;
      long_fired_in   = long_fired_ff;
      vlong_fired_in  = vlong_fired_ff;
      short_in        = short_ff;
      long_in         = long_ff;
      vlong_in        = vlong_ff;
      press_time_in   = press_time_ff;
      release_time_in = release_time_ff;
      if (ctl.sample) begin
         long_fired_in  = lf_mid;
         vlong_fired_in = vf_mid;
         if (press_ok) begin
            held_in       = 1'b1;
            press_time_in = ctl.now_ms;
         end else if (rel_ok) begin
            held_in         = 1'b0;
            release_time_in = ctl.now_ms;
            if (!long_fired_ff && !vlong_fired_ff) begin
               short_in = 1'b1;
            end
         end
         if (held_in) begin
            if (!lf_mid && (dur >= bpc_pkg::TIME_W'(ctl.long_hold_ms))) begin
               long_fired_in = 1'b1;
               long_in       = 1'b1;
            end
            if (!vf_mid && (dur >= bpc_pkg::TIME_W'(ctl.very_long_hold_ms))) begin
               vlong_fired_in = 1'b1;
               vlong_in       = 1'b1;
            end
         end
      end else if (ctl.clear) begin
         short_in = 1'b0;
         long_in  = 1'b0;
         vlong_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff         <= 1'b0;
         long_fired_ff   <= 1'b0;
         vlong_fired_ff  <= 1'b0;
         short_ff        <= 1'b0;
         long_ff         <= 1'b0;
         vlong_ff        <= 1'b0;
         press_time_ff   <= '0;
         release_time_ff <= '0;
      end else begin
         held_ff         <= held_in;
         long_fired_ff   <= long_fired_in;
         vlong_fired_ff  <= vlong_fired_in;
         short_ff        <= short_in;
         long_ff         <= long_in;
         vlong_ff        <= vlong_in;
         press_time_ff   <= press_time_in;
         release_time_ff <= release_time_in;
      end
   end

   // status, flags as they stand before this word
   assign stat.held              = held_ff;
   assign stat.held_next         = held_in;
   assign stat.short_pending     = short_ff;
   assign stat.long_pending      = long_ff;
   assign stat.very_long_pending = vlong_ff;

   `ASSERT_NEXT(a_clear_flags, ctl.clear && !ctl.sample, !short_ff && !long_ff && !vlong_ff, "read did not clear flags")
   `ASSERT_NEXT(a_press_time, ctl.sample && press_ok, held_ff && (press_time_ff == $past(ctl.now_ms)), "press not recorded")
   `ASSERT_SAME(a_short_on_release, $rose(short_ff), !held_ff, "short flag set while held")

endmodule

FILE: src/button_press_classifier.sv
// path: a request word is held in the request stage, then its response in the response register
// throughput: one word per cycle while rsp accepts; per-button lanes update in one pass each cycle
// the response register decouples the sides, so stalls on rsp only hold the request stage
// reset: synchronous, all buttons released, flags and timestamps cleared,
// registers back to debounce 50, long hold 600, very long hold 3000
module button_press_classifier #(
   parameter int NUM_BUTTONS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   bpc_req_if.sink                       req_if,
   bpc_rsp_if.source                     rsp_if,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bpc_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [bpc_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [bpc_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int LANE_W = (NUM_BUTTONS > bpc_pkg::MASK_W) ? NUM_BUTTONS : bpc_pkg::MASK_W;

   // configuration registers
   logic [bpc_pkg::THR_W-1:0] debounce_ff, debounce_in;
   logic [bpc_pkg::THR_W-1:0] long_hold_ff, long_hold_in;
   logic [bpc_pkg::THR_W-1:0] vlong_hold_ff, vlong_hold_in;
   logic                      csr_wr;

   // request stage
   logic                         stage_valid_ff, stage_valid_in;
   bpc_pkg::cmd_type             stage_cmd_ff;
   logic [bpc_pkg::TIME_W-1:0]   stage_now_ff;
   logic [bpc_pkg::PIN_W-1:0]    stage_pins_ff;
   logic [bpc_pkg::IDX_W-1:0]    stage_idx_ff;
   logic                         req_take;
   logic                         advance;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_short_ff, rsp_long_ff, rsp_vlong_ff, rsp_held_ff;
   logic [bpc_pkg::MASK_W-1:0]   rsp_mask_ff;

   // lane signals
   bpc_pkg::lane_ctl_type        lane_ctl  [NUM_BUTTONS];
   bpc_pkg::lane_stat_type       lane_stat [NUM_BUTTONS];
   logic [LANE_W-1:0]            sel_vec;
   logic [LANE_W-1:0]            held_next_vec;
   logic [LANE_W-1:0]            short_vec, long_vec, vlong_vec, held_vec;

   // apb write decode
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      debounce_in   = debounce_ff;
      long_hold_in  = long_hold_ff;
      vlong_hold_in = vlong_hold_ff;
      if (csr_wr) begin
         case (bpc_pkg::reg_idx_type'(csr_paddr[3:2]))
            bpc_pkg::REG_DEBOUNCE: begin
               debounce_in = csr_pwdata[bpc_pkg::THR_W-1:0];
            end
            bpc_pkg::REG_LONG_HOLD: begin
               long_hold_in = csr_pwdata[bpc_pkg::THR_W-1:0];
            end
            bpc_pkg::REG_VERY_LONG_HOLD: begin
               vlong_hold_in = csr_pwdata[bpc_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // apb read mux
   always_comb begin
      case (bpc_pkg::reg_idx_type'(csr_paddr[3:2]))
         bpc_pkg::REG_DEBOUNCE:       csr_prdata = bpc_pkg::CSR_DW'(debounce_ff);
         bpc_pkg::REG_LONG_HOLD:      csr_prdata = bpc_pkg::CSR_DW'(long_hold_ff);
         bpc_pkg::REG_VERY_LONG_HOLD: csr_prdata = bpc_pkg::CSR_DW'(vlong_hold_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= bpc_pkg::DEBOUNCE_RST;
         long_hold_ff  <= bpc_pkg::LONG_HOLD_RST;
         vlong_hold_ff <= bpc_pkg::VERY_LONG_HOLD_RST;
      end else begin
         debounce_ff   <= debounce_in;
         long_hold_ff  <= long_hold_in;
         vlong_hold_ff <= vlong_hold_in;
      end
   end

   // handshake: stage moves on when the response register is free or drains
   assign advance      = stage_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !stage_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_cmd_ff  <= bpc_pkg::cmd_type'(req_if.cmd);
         stage_now_ff  <= req_if.now_ms;
         stage_pins_ff <= req_if.pin_low_mask;
         stage_idx_ff  <= req_if.button_index;
      end
   end

   // one lane per button
   for (genvar k = 0; k < LANE_W; k++) begin : g_lane
      if (k < NUM_BUTTONS) begin : g_used
         logic down;
         if (k < bpc_pkg::PIN_W) begin : g_pin
            assign down = stage_pins_ff[k];
         end else begin : g_nopin
            assign down = 1'b0;
         end

         assign sel_vec[k] = (stage_cmd_ff == bpc_pkg::CMD_READ) &&
                             ({2'b00, stage_idx_ff} == 5'(k));

         assign lane_ctl[k].sample = advance && (stage_cmd_ff == bpc_pkg::CMD_SAMPLE);
         assign lane_ctl[k].clear  = advance && sel_vec[k];
         assign lane_ctl[k].down   = down;
         assign lane_ctl[k].now_ms = stage_now_ff;
         assign lane_ctl[k].debounce_ms       = debounce_ff;
         assign lane_ctl[k].long_hold_ms      = long_hold_ff;
         assign lane_ctl[k].very_long_hold_ms = vlong_hold_ff;

         bpc_lane u_lane (
            .clock (clock),
            .reset (reset),
            .ctl   (lane_ctl[k]),
            .stat  (lane_stat[k])
         );

         assign held_next_vec[k] = lane_stat[k].held_next;
         assign short_vec[k]     = lane_stat[k].short_pending;
         assign long_vec[k]      = lane_stat[k].long_pending;
         assign vlong_vec[k]     = lane_stat[k].very_long_pending;
         assign held_vec[k]      = lane_stat[k].held;
      end else begin : g_pad
         assign sel_vec[k]       = 1'b0;
         assign held_next_vec[k] = 1'b0;
         assign short_vec[k]     = 1'b0;
         assign long_vec[k]      = 1'b0;
         assign vlong_vec[k]     = 1'b0;
         assign held_vec[k]      = 1'b0;
      end
   end

   // response payload: chosen button before clearing, mask after the word
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_short_ff <= |(sel_vec & short_vec);
         rsp_long_ff  <= |(sel_vec & long_vec);
         rsp_vlong_ff <= |(sel_vec & vlong_vec);
         rsp_held_ff  <= |(sel_vec & held_vec);
         rsp_mask_ff  <= held_next_vec[bpc_pkg::MASK_W-1:0];
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.short_press     = rsp_short_ff;
   assign rsp_if.long_press      = rsp_long_ff;
   assign rsp_if.very_long_press = rsp_vlong_ff;
   assign rsp_if.is_held         = rsp_held_ff;
   assign rsp_if.held_mask       = rsp_mask_ff;

endmodule
